>>> hw/rtl/bcms_pkg.sv
// shared constants, state encoding and unit handshake types of the battery charge model step
// no dependencies
`default_nettype none

package bcms_pkg;

    // battery model constants
    localparam int unsigned CAPACITY_AH  = 910;
    localparam int unsigned MIN_VOLT     = 11 * 100;
    localparam int unsigned MAX_VOLT     = 13 * 100;
    localparam int unsigned CHARGE_VOLT  = 15 * 100;
    localparam int unsigned LIMIT_VOLT   = 16 * 100;
    localparam int unsigned START_PCT    = 20;
    localparam int unsigned TOL_PCT      = 10;
    localparam int unsigned WARN_VOLT    = CHARGE_VOLT + (CHARGE_VOLT * TOL_PCT) / 100;
    localparam int unsigned FAIL_VOLT    = LIMIT_VOLT + (LIMIT_VOLT * TOL_PCT) / 100;
    localparam int unsigned POWER_SAT    = 40000;
    localparam int unsigned CUR_DIVISOR  = CHARGE_VOLT / 100 - 12;
    localparam int unsigned MS_PER_HOUR  = 3600;
    localparam int unsigned PWR_SCALE    = 100000;
    localparam int unsigned PCT_DIVISOR  = 100;
    localparam int unsigned CAP_UAH      = CAPACITY_AH * 1000000;
    localparam int unsigned LVL_DIVISOR  = CAPACITY_AH * 100;
    localparam int unsigned Q_RESET      = ((START_PCT * CAPACITY_AH) / 100) * 1000000;
    localparam int unsigned LVL_RESET    = Q_RESET / LVL_DIVISOR;
    localparam int unsigned TV_RESET     = MIN_VOLT
        + ((Q_RESET / (CAPACITY_AH * 10000)) * (MAX_VOLT - MIN_VOLT)) / 100;

    // serial multiplier geometry
    localparam int unsigned MUL_A_W   = 18;
    localparam int unsigned MUL_B_W   = 16;
    localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W);

    // serial divider geometry
    localparam int unsigned DIV_N_W   = 34;
    localparam int unsigned DIV_D_W   = 17;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W + 1);

    // quotient bits needed by each division
    localparam int unsigned N_CUR = 20;
    localparam int unsigned N_CAP = 32;
    localparam int unsigned N_ADD = 34;
    localparam int unsigned N_LVL = 30;
    localparam int unsigned N_PCT = 14;
    localparam int unsigned N_PWR = 29;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_CUR,
        ST_DIV_CUR,
        ST_MUL_CAP,
        ST_DIV_CAP,
        ST_MUL_ADD,
        ST_DIV_ADD,
        ST_DIV_LVL,
        ST_DIV_PCT,
        ST_MUL_PWR,
        ST_DIV_PWR,
        ST_OUT
    } bcms_state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] nbits;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/bcms_ser_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on bcms_pkg
`default_nettype none

module bcms_ser_mul import bcms_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [MUL_A_W-1:0] mcand,
    input  wire logic [MUL_B_W-1:0] mplier,
    output unit_stat_t              stat,
    output logic      [MUL_P_W-1:0] product
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_P_W-1:0]   p_reg;
    logic [MUL_A_W:0]     sum;

    // add the multiplicand into the upper half when the low bit is set
    always_comb begin
        sum = {1'b0, p_reg[MUL_P_W-1:MUL_B_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + MUL_CNT_W'(1);
                if (cnt_reg == MUL_CNT_W'(MUL_B_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            a_reg <= mcand;
            p_reg <= {{MUL_A_W{1'b0}}, mplier};
        end else if (busy_reg) begin
            p_reg <= {sum, p_reg[MUL_B_W-1:1]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = p_reg;

endmodule

`default_nettype wire

>>> hw/rtl/bcms_ser_div.sv
// bit-serial restoring divider, one quotient bit per cycle, dividend left aligned
// depends on bcms_pkg
`default_nettype none

module bcms_ser_div import bcms_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire div_cmd_t           cmd,
    input  wire logic [DIV_N_W-1:0] dividend,
    input  wire logic [DIV_D_W-1:0] divisor,
    output unit_stat_t              stat,
    output logic      [DIV_N_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] nbits_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   dvs_reg;
    logic [DIV_N_W-1:0]   dq_reg;
    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W+1:0]   trial;
    logic                 take;

    always_comb begin
        shifted = {rem_reg, dq_reg[DIV_N_W-1]};
        trial   = {1'b0, shifted} - {2'b00, dvs_reg};
        take    = !trial[DIV_D_W+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == nbits_reg - DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start && !busy_reg) begin
            rem_reg   <= '0;
            dq_reg    <= dividend;
            dvs_reg   <= divisor;
            nbits_reg <= cmd.nbits;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the low bits hold it
            rem_reg <= take ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
            dq_reg  <= {dq_reg[DIV_N_W-2:0], take};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dq_reg;

endmodule

`default_nettype wire

>>> hw/rtl/bcms_apb_regs.sv
// apb configuration register: tick period in milliseconds
// depends on bcms_pkg
`default_nettype none

module bcms_apb_regs import bcms_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [15:0] tick_period
);

    localparam logic ADDR_TICK = 1'b0;

    logic [15:0] tick_reg;
    logic        wr_tick;

    assign pready  = 1'b1;
    assign wr_tick = psel && penable && pwrite && (paddr[2] == ADDR_TICK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= 16'd100;
        end else if (wr_tick) begin
            tick_reg <= pwdata[15:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            ADDR_TICK: prdata = {16'd0, tick_reg};
            default:   prdata = 32'd0;
        endcase
    end

    assign tick_period = tick_reg;

endmodule

`default_nettype wire

>>> hw/rtl/battery_charge_model_step_core.sv
// lead battery charge model, one simulation tick per input word
// depends on bcms_pkg, bcms_ser_mul, bcms_ser_div, bcms_apb_regs
// sequence: a tick that does not charge (failed, frozen or charger below battery) goes straight
//   to the output state; a charging tick runs four 16-bit serial products and six serial
//   divisions of 14 to 34 quotient bits
// throughput: one word at a time; the next word is taken once the result sits in the output
//   register, while that result still waits for m_ready
// reset: synchronous active low; charge 20 percent, voltage 1140 cV, latches clear, tick 100 ms
`default_nettype none

module battery_charge_model_step_core import bcms_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input words
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_charger_voltage,
    input  wire logic [15:0] s_available_power,
    // result words
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [11:0] m_consumed_power,
    output logic      [17:0] m_charge_current_ma,
    output logic      [10:0] m_battery_voltage,
    output logic      [13:0] m_state_of_charge,
    output logic             m_overvoltage_warning,
    output logic             m_battery_failed,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    // sequencer
    bcms_state_t state_reg, state_next;
    logic        issued_reg, issued_next;

    // model state
    logic [29:0] q_reg;        // stored charge, uAh
    logic [10:0] tv_reg;       // terminal voltage, cV
    logic [13:0] lvl_reg;      // state of charge, 0.01 percent
    logic        wl_reg;       // sticky overvoltage warning
    logic        fl_reg;       // failure latch

    // per-word working registers
    logic [10:0] vin_reg;      // charger voltage, low 11 bits, used only while charging (<= fail limit)
    logic [15:0] pw_reg;       // saturated available power
    logic [17:0] cur_reg;
    logic [11:0] power_reg;
    logic        warn_reg;

    // output register
    logic        m_valid_reg;
    logic [11:0] m_power_reg;
    logic [17:0] m_cur_reg;
    logic [10:0] m_tv_reg;
    logic [13:0] m_lvl_reg;
    logic        m_warn_reg;
    logic        m_fail_reg;

    logic [15:0] tick_period;

    // unit hookup
    logic               mul_start;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_prod;
    unit_stat_t         mul_stat;
    div_cmd_t           div_cmd;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic [DIV_N_W-1:0] div_quo;
    unit_stat_t         div_stat;

    logic        accept;
    logic        out_load;
    logic        goes_charging;
    logic [10:0] vdiff;
    logic [30:0] q_sum;

    bcms_apb_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .tick_period (tick_period)
    );

    bcms_ser_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .stat    (mul_stat),
        .product (mul_prod)
    );

    bcms_ser_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (div_cmd),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // charging starts only when alive, below the destructive limit and not under the battery
    assign goes_charging = !fl_reg
                        && (s_charger_voltage <= 16'(FAIL_VOLT))
                        && (s_charger_voltage >= {5'd0, tv_reg});

    assign vdiff = vin_reg - tv_reg;
    assign q_sum = {1'b0, q_reg} + 31'(div_quo[22:0]);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_valid) state_next = goes_charging ? ST_MUL_CUR : ST_OUT;
            ST_MUL_CUR: if (mul_stat.done) state_next = ST_DIV_CUR;
            ST_DIV_CUR: if (div_stat.done) state_next = ST_MUL_CAP;
            ST_MUL_CAP: if (mul_stat.done) state_next = ST_DIV_CAP;
            ST_DIV_CAP: if (div_stat.done) state_next = ST_MUL_ADD;
            ST_MUL_ADD: if (mul_stat.done) state_next = ST_DIV_ADD;
            ST_DIV_ADD: if (div_stat.done) state_next = ST_DIV_LVL;
            ST_DIV_LVL: if (div_stat.done) state_next = ST_DIV_PCT;
            ST_DIV_PCT: if (div_stat.done) state_next = ST_MUL_PWR;
            ST_MUL_PWR: if (mul_stat.done) state_next = ST_DIV_PWR;
            ST_DIV_PWR: if (div_stat.done) state_next = ST_OUT;
            ST_OUT:     if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: unit launches and operand selection
    always_comb begin
        s_ready       = 1'b0;
        mul_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        div_cmd.start = 1'b0;
        div_cmd.nbits = '0;
        div_dividend  = '0;
        div_divisor   = '0;
        unique case (state_reg) inside
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_MUL_CUR, ST_MUL_CAP, ST_MUL_ADD, ST_MUL_PWR: begin
                mul_start = !issued_reg;
            end
            ST_DIV_CUR, ST_DIV_CAP, ST_DIV_ADD, ST_DIV_LVL, ST_DIV_PCT, ST_DIV_PWR: begin
                div_cmd.start = !issued_reg;
            end
            default: begin
            end
        endcase

        unique case (state_reg)
            // (vin - vbat) * capacity
            ST_MUL_CUR: begin
                mul_a = MUL_A_W'(CAPACITY_AH);
                mul_b = {5'd0, vdiff};
            end
            // divided by the charge voltage span
            ST_DIV_CUR: begin
                div_cmd.nbits = DIV_CNT_W'(N_CUR);
                div_dividend  = DIV_N_W'(mul_prod) << (DIV_N_W - N_CUR);
                div_divisor   = DIV_D_W'(CUR_DIVISOR);
            end
            // power cap numerator
            ST_MUL_CAP: begin
                mul_a = MUL_A_W'(PWR_SCALE);
                mul_b = pw_reg;
            end
            ST_DIV_CAP: begin
                div_cmd.nbits = DIV_CNT_W'(N_CAP);
                div_dividend  = DIV_N_W'(mul_prod) << (DIV_N_W - N_CAP);
                div_divisor   = {6'd0, vin_reg};
            end
            // charge added this tick
            ST_MUL_ADD: begin
                mul_a = cur_reg;
                mul_b = tick_period;
            end
            ST_DIV_ADD: begin
                div_cmd.nbits = DIV_CNT_W'(N_ADD);
                div_dividend  = DIV_N_W'(mul_prod) << (DIV_N_W - N_ADD);
                div_divisor   = DIV_D_W'(MS_PER_HOUR);
            end
            // state of charge, then whole percent for the voltage
            ST_DIV_LVL: begin
                div_cmd.nbits = DIV_CNT_W'(N_LVL);
                div_dividend  = DIV_N_W'(q_reg) << (DIV_N_W - N_LVL);
                div_divisor   = DIV_D_W'(LVL_DIVISOR);
            end
            ST_DIV_PCT: begin
                div_cmd.nbits = DIV_CNT_W'(N_PCT);
                div_dividend  = DIV_N_W'(lvl_reg) << (DIV_N_W - N_PCT);
                div_divisor   = DIV_D_W'(PCT_DIVISOR);
            end
            // consumed power
            ST_MUL_PWR: begin
                mul_a = cur_reg;
                mul_b = {5'd0, vin_reg};
            end
            ST_DIV_PWR: begin
                div_cmd.nbits = DIV_CNT_W'(N_PWR);
                div_dividend  = DIV_N_W'(mul_prod) << (DIV_N_W - N_PWR);
                div_divisor   = DIV_D_W'(PWR_SCALE);
            end
            default: begin
            end
        endcase
    end

    // one launch per unit state
    always_comb begin
        if (state_next != state_reg) begin
            issued_next = 1'b0;
        end else begin
            issued_next = issued_reg || mul_start || div_cmd.start;
        end
    end

    // control and model state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            q_reg       <= 30'(Q_RESET);
            tv_reg      <= 11'(TV_RESET);
            lvl_reg     <= 14'(LVL_RESET);
            wl_reg      <= 1'b0;
            fl_reg      <= 1'b0;
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // warning and failure latches move only on a live battery
            if (accept && !fl_reg) begin
                if (s_charger_voltage > 16'(WARN_VOLT) && !wl_reg) begin
                    wl_reg <= 1'b1;
                end else if (s_charger_voltage < 16'(CHARGE_VOLT)) begin
                    wl_reg <= 1'b0;
                end
                if (s_charger_voltage > 16'(FAIL_VOLT)) begin
                    fl_reg <= 1'b1;
                end
            end

            // clamp at full capacity
            if (state_reg == ST_DIV_ADD && div_stat.done) begin
                q_reg <= (q_sum > 31'(CAP_UAH)) ? 30'(CAP_UAH) : q_sum[29:0];
            end
            if (state_reg == ST_DIV_LVL && div_stat.done) begin
                lvl_reg <= div_quo[13:0];
            end
            // 1100 cV plus 2 cV per whole percent
            if (state_reg == ST_DIV_PCT && div_stat.done) begin
                tv_reg <= 11'(MIN_VOLT) + {3'd0, div_quo[6:0], 1'b0};
            end
        end
    end

    // per-word payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            vin_reg   <= s_charger_voltage[10:0];
            pw_reg    <= (s_available_power > 16'(POWER_SAT)) ? 16'(POWER_SAT)
                                                              : s_available_power;
            cur_reg   <= '0;
            power_reg <= '0;
            warn_reg  <= !fl_reg && (s_charger_voltage > 16'(WARN_VOLT)) && !wl_reg;
        end
        if (state_reg == ST_DIV_CUR && div_stat.done) begin
            cur_reg <= div_quo[17:0];
        end
        // power cap: the capped quotient fits 22 bits
        if (state_reg == ST_DIV_CAP && div_stat.done) begin
            if (div_quo[21:0] < {4'd0, cur_reg}) begin
                cur_reg <= div_quo[17:0];
            end
        end
        if (state_reg == ST_DIV_PWR && div_stat.done) begin
            power_reg <= div_quo[11:0] + 12'd1;
        end

        if (out_load) begin
            m_power_reg <= power_reg;
            m_cur_reg   <= cur_reg;
            m_tv_reg    <= tv_reg;
            m_lvl_reg   <= lvl_reg;
            m_warn_reg  <= warn_reg;
            m_fail_reg  <= fl_reg;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_consumed_power      = m_power_reg;
    assign m_charge_current_ma   = m_cur_reg;
    assign m_battery_voltage     = m_tv_reg;
    assign m_state_of_charge     = m_lvl_reg;
    assign m_overvoltage_warning = m_warn_reg;
    assign m_battery_failed      = m_fail_reg;

    // the two serial units are never at work together
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider busy at once");

    // stored charge never passes full capacity
    a_charge_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_reg <= 30'(CAP_UAH))
        else $error("stored charge above capacity");

    // terminal voltage stays on the model's range
    a_volt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (tv_reg >= 11'(MIN_VOLT)) && (tv_reg <= 11'(MAX_VOLT)))
        else $error("terminal voltage out of range");

    // a failed battery stays failed
    a_fail_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        fl_reg |=> fl_reg)
        else $error("failure latch cleared");

    // a failed result draws nothing
    a_fail_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_fail_reg) |-> (m_cur_reg == '0) && (m_power_reg == '0))
        else $error("failed result reports current or power");

endmodule

`default_nettype wire
